// File: rtl/isf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isf_pkg
// Shared types and constants of the sorted IPv4 address store.
// ----------------------------------------------------------------------------
package isf_pkg;

    localparam int ADDR_BITS   = 32;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    // Request codes
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_NEXT  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Filter selections
    typedef enum logic [1:0] {
        PASS_ALL   = 2'd0,
        PASS_FIRST = 2'd1,
        PASS_PAIR  = 2'd2,
        PASS_ANY   = 2'd3
    } pass_t;

    // Result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_ENTRY     = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SINGLE_FIRST = 2'd0,
        REG_PAIR_FIRST   = 2'd1,
        REG_PAIR_SECOND  = 2'd2,
        REG_ANY_OCTET    = 2'd3
    } reg_idx_t;

    localparam logic [7:0] SINGLE_FIRST_RST = 8'd1;
    localparam logic [7:0] PAIR_FIRST_RST   = 8'd46;
    localparam logic [7:0] PAIR_SECOND_RST  = 8'd70;
    localparam logic [7:0] ANY_OCTET_RST    = 8'd46;

    typedef struct packed {
        logic [7:0] single_first_octet;
        logic [7:0] pair_first_octet;
        logic [7:0] pair_second_octet;
        logic [7:0] any_octet_value;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_PUT,
        S_SCAN,
        S_FINISH
    } state_t;

endpackage

// File: rtl/isf_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isf_cfg
// APB-style register bank holding the four filter octet values.
// ----------------------------------------------------------------------------
module isf_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [isf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [isf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [isf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output isf_pkg::cfg_t                  cfg
);
    import isf_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    reg_idx_t   idx;
    logic [7:0] rd_byte;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SINGLE_FIRST: cfg_next.single_first_octet = pwdata[7:0];
                REG_PAIR_FIRST:   cfg_next.pair_first_octet   = pwdata[7:0];
                REG_PAIR_SECOND:  cfg_next.pair_second_octet  = pwdata[7:0];
                REG_ANY_OCTET:    cfg_next.any_octet_value    = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SINGLE_FIRST: rd_byte = cfg_reg.single_first_octet;
            REG_PAIR_FIRST:   rd_byte = cfg_reg.pair_first_octet;
            REG_PAIR_SECOND:  rd_byte = cfg_reg.pair_second_octet;
            REG_ANY_OCTET:    rd_byte = cfg_reg.any_octet_value;
            default:          rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(CFG_DATA_W-8){1'b0}}, rd_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.single_first_octet <= SINGLE_FIRST_RST;
            cfg_reg.pair_first_octet   <= PAIR_FIRST_RST;
            cfg_reg.pair_second_octet  <= PAIR_SECOND_RST;
            cfg_reg.any_octet_value    <= ANY_OCTET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/isf_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isf_match
// Octet filter applied to one stored address during a scan.
// ----------------------------------------------------------------------------
module isf_match (
    input  logic [isf_pkg::ADDR_BITS-1:0] value,
    input  isf_pkg::pass_t                sel,
    input  isf_pkg::cfg_t                 cfg,
    output logic                          hit
);
    import isf_pkg::*;

    logic [7:0] oct0;
    logic [7:0] oct1;
    logic [7:0] oct2;
    logic [7:0] oct3;

    assign oct0 = value[31:24];
    assign oct1 = value[23:16];
    assign oct2 = value[15:8];
    assign oct3 = value[7:0];

    always_comb
    begin
        case (sel)
            PASS_ALL:   hit = 1'b1;
            PASS_FIRST: hit = (oct0 == cfg.single_first_octet);
            PASS_PAIR:  hit = (oct0 == cfg.pair_first_octet) &&
                              (oct1 == cfg.pair_second_octet);
            PASS_ANY:   hit = (oct0 == cfg.any_octet_value) ||
                              (oct1 == cfg.any_octet_value) ||
                              (oct2 == cfg.any_octet_value) ||
                              (oct3 == cfg.any_octet_value);
            default:    hit = 1'b0;
        endcase
    end

endmodule

// File: rtl/isf_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isf_engine
// Sequencer around the address memory: insertion shift, filtered scan,
// clear, and the output register.
// ----------------------------------------------------------------------------
module isf_engine #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [isf_pkg::ADDR_BITS-1:0] address_in,
    input  logic [1:0]                    pass_select,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [isf_pkg::ADDR_BITS-1:0] address_out,
    input  isf_pkg::cfg_t                 cfg
);
    import isf_pkg::*;

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

    logic [ADDR_BITS-1:0] mem [STORE_DEPTH];
    logic [ADDR_BITS-1:0] rd_data;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [ADDR_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     cursor_reg, cursor_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    pass_t                sel_reg, sel_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic [ADDR_BITS-1:0] res_addr_reg, res_addr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [ADDR_BITS-1:0] out_addr_reg, out_addr_next;

    logic                 in_fire;
    logic                 out_free;
    logic                 load_full;
    logic                 load_empty;
    logic [CNT_W-1:0]     cur_start;
    logic [CNT_W-1:0]     cur_clamp;
    logic                 scan_none;
    logic                 hit;
    logic                 load_stop;
    logic [CNT_W-1:0]     idx_inc;
    logic                 scan_end;

    isf_match u_match (
        .value (rd_data),
        .sel   (sel_reg),
        .cfg   (cfg),
        .hit   (hit)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[mem_raddr];
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign load_full  = (count_reg >= DEPTH_C);
    assign load_empty = (count_reg == '0);
    assign cur_start  = restart ? '0 : cursor_reg;
    assign cur_clamp  = (cur_start > count_reg) ? count_reg : cur_start;
    assign scan_none  = (cur_clamp >= count_reg);
    assign load_stop  = (rd_data >= addr_reg);
    assign idx_inc    = idx_reg + ONE_C;
    assign scan_end   = (idx_inc == count_reg);

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign address_out = out_addr_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (req_t'(req_type))
                        REQ_LOAD:
                            state_next = (load_full || load_empty) ? S_FINISH : S_LOAD;
                        REQ_NEXT:
                            state_next = scan_none ? S_FINISH : S_SCAN;
                        default:
                            state_next = S_FINISH;
                    endcase
                end
            end
            S_LOAD:
            begin
                if (load_stop)
                    state_next = S_FINISH;
                else if (idx_reg == ONE_C)
                    state_next = S_PUT;
            end
            S_PUT:
                state_next = S_FINISH;
            S_SCAN:
            begin
                if (hit || scan_end)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        sel_next        = sel_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg[IDX_W-1:0];
        mem_wdata       = addr_reg;
        mem_raddr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    addr_next       = address_in;
                    sel_next        = pass_t'(pass_select);
                    res_status_next = ST_DONE;
                    res_addr_next   = '0;
                    case (req_t'(req_type))
                        REQ_LOAD:
                        begin
                            if (load_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (load_empty)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = address_in;
                                count_next = count_reg + ONE_C;
                            end
                            else
                            begin
                                // walk down from the tail, reading one entry ahead
                                mem_raddr = IDX_W'(count_reg - ONE_C);
                                idx_next  = count_reg;
                            end
                        end
                        REQ_NEXT:
                        begin
                            if (scan_none)
                            begin
                                res_status_next = ST_EXHAUSTED;
                                cursor_next     = count_reg;
                            end
                            else
                            begin
                                mem_raddr = cur_clamp[IDX_W-1:0];
                                idx_next  = cur_clamp;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        default:
                        begin
                            res_status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                // rd_data holds entry idx-1; write it or the new address at idx
                mem_we = 1'b1;
                if (load_stop)
                begin
                    mem_wdata  = addr_reg;
                    count_next = count_reg + ONE_C;
                end
                else
                begin
                    mem_wdata = rd_data;
                    mem_raddr = IDX_W'(idx_reg - TWO_C);
                    idx_next  = idx_reg - ONE_C;
                end
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_wdata  = addr_reg;
                count_next = count_reg + ONE_C;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_status_next = ST_ENTRY;
                    res_addr_next   = rd_data;
                    cursor_next     = idx_inc;
                end
                else if (scan_end)
                begin
                    res_status_next = ST_EXHAUSTED;
                    res_addr_next   = '0;
                    cursor_next     = count_reg;
                end
                else
                begin
                    mem_raddr = IDX_W'(idx_inc);
                    idx_next  = idx_inc;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        addr_reg       <= addr_next;
        sel_reg        <= sel_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

endmodule

// File: rtl/ipv4_sort_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_sort_filter
// Sorted IPv4 address store with load, filtered read-out and clear.
//
// Input channel (in_valid/in_ready) carries one request item: load an
// address, fetch the next address passing a filter, or clear the store.
// Output channel (out_valid/out_ready) returns exactly one result item per
// request: status and, for a returned entry, the address.
// Addresses live in one STORE_DEPTH x 32 memory with a registered read.
// Steps from acceptance to result valid:
//   load:  each stored entry smaller than the new address is shifted up
//          (one entry shifted per cycle); none into an empty or full store
//   next:  entries are examined from the cursor (one compared per cycle)
//   clear and unused codes: no memory steps
// in_ready is high whenever the sequencer is idle; at most one item is in
// work at a time, so a new item is taken only after the last result has
// left the sequencer. A finished result waits in the output register
// while the next item is accepted; a result that finds that register still
// held back by out_ready waits in the sequencer until it drains.
// Reset empties the store and the pass cursor and loads the filter defaults;
// no memory sweep is needed.
// ----------------------------------------------------------------------------
module ipv4_sort_filter #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     req_type,
    input  logic [isf_pkg::ADDR_BITS-1:0]  address_in,
    input  logic [1:0]                     pass_select,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [isf_pkg::ADDR_BITS-1:0]  address_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [isf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [isf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [isf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import isf_pkg::*;

    cfg_t cfg;

    isf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    isf_engine #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .address_in  (address_in),
        .pass_select (pass_select),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .address_out (address_out),
        .cfg         (cfg)
    );

endmodule

// File: rtl/isf_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isf_chk
// Port-level checks of the sorted address store, bound to the top level.
// ----------------------------------------------------------------------------
module isf_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [1:0]                     status,
    input logic [isf_pkg::ADDR_BITS-1:0]  address_out,
    input logic                           pready
);
    import isf_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(address_out))
        else $error("result changed while stalled");

    // Only a returned entry carries an address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_ENTRY |-> address_out == '0)
        else $error("address_out nonzero without an entry");

    // One item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    // An accepted item cannot produce its result in the next cycle
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared one cycle after acceptance");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind ipv4_sort_filter isf_chk u_isf_chk (.*);

// File: sim/tb_ipv4_sort_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_sort_filter
// Self-checking bench for the sorted IPv4 address store. A queue-fed driver
// offers load, next and clear items with random gaps. A shadow copy of the
// store predicts every status and address. A monitor compares the results in
// order, while the result side stalls at random and twice for a long stretch.
// ----------------------------------------------------------------------------
module tb_ipv4_sort_filter;
    import isf_pkg::*;

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = DEPTH + 40;
    localparam int SQUEEZE_LEN = 400;

    typedef struct packed {
        req_t        kind;
        logic [31:0] addr;
        pass_t       sel;
        logic        restart;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] addr;
    } result_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [1:0]            req_type    = REQ_LOAD;
    logic [ADDR_BITS-1:0]  address_in  = '0;
    logic [1:0]            pass_select = PASS_ALL;
    logic                  restart     = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [1:0]            status;
    logic [ADDR_BITS-1:0]  address_out;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow of the block's state and filter settings
    logic [31:0] shadow_store [DEPTH];
    int          shadow_count  = 0;
    int          shadow_cursor = 0;
    cfg_t        shadow_cfg    = '{SINGLE_FIRST_RST, PAIR_FIRST_RST,
                                   PAIR_SECOND_RST, ANY_OCTET_RST};

    req_item_t   pending_reqs[$];
    result_t     expected_results[$];
    logic [31:0] recent_loads[$];
    req_item_t   drive_item;
    req_item_t   seen_item;
    result_t     want;
    result_t     predicted;

    int mismatches   = 0;
    int in_gap       = 0;
    int out_stall    = 0;
    int squeeze_left = 0;
    int hs_count     = 0;
    int cycle_count  = 0;
    bit in_steady    = 1'b0;
    bit out_steady   = 1'b0;

    ipv4_sort_filter #(
        .STORE_DEPTH(DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .address_in (address_in),
        .pass_select(pass_select),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .address_out(address_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic bit octet_filter_hit(input logic [31:0] a, input pass_t sel);
        case (sel)
            PASS_ALL:   return 1'b1;
            PASS_FIRST: return a[31:24] == shadow_cfg.single_first_octet;
            PASS_PAIR:  return a[31:24] == shadow_cfg.pair_first_octet &&
                               a[23:16] == shadow_cfg.pair_second_octet;
            default:    return a[31:24] == shadow_cfg.any_octet_value ||
                               a[23:16] == shadow_cfg.any_octet_value ||
                               a[15:8]  == shadow_cfg.any_octet_value ||
                               a[7:0]   == shadow_cfg.any_octet_value;
        endcase
    endfunction

    function automatic result_t apply_request(input req_item_t it);
        result_t r;
        int      pos;
        int      i;
        r.status = ST_DONE;
        r.addr   = '0;
        case (it.kind)
            REQ_LOAD:
            begin
                if (shadow_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // new address goes after every entry that is >= it
                    pos = 0;
                    while (pos < shadow_count && shadow_store[pos] >= it.addr)
                        pos++;
                    for (i = shadow_count; i > pos; i--)
                        shadow_store[i] = shadow_store[i-1];
                    shadow_store[pos] = it.addr;
                    shadow_count++;
                end
            end
            REQ_NEXT:
            begin
                if (it.restart)
                    shadow_cursor = 0;
                if (shadow_cursor > shadow_count)
                    shadow_cursor = shadow_count;
                r.status = ST_EXHAUSTED;
                for (i = shadow_cursor; i < shadow_count; i++)
                begin
                    if (octet_filter_hit(shadow_store[i], it.sel))
                    begin
                        r.status = ST_ENTRY;
                        r.addr   = shadow_store[i];
                        break;
                    end
                end
                shadow_cursor = (r.status == ST_ENTRY) ? i + 1 : shadow_count;
            end
            REQ_CLEAR:
            begin
                shadow_count  = 0;
                shadow_cursor = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int gap_len(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // bias addresses toward the filter settings and toward duplicates
    function automatic logic [31:0] pick_address();
        logic [31:0] a;
        int          k;
        a = $urandom;
        case ($urandom_range(0, 9))
            4: a[31:24] = shadow_cfg.single_first_octet;
            5: a[31:16] = {shadow_cfg.pair_first_octet, shadow_cfg.pair_second_octet};
            6:
            begin
                k = $urandom_range(0, 3);
                a[8*k +: 8] = shadow_cfg.any_octet_value;
            end
            7:
            begin
                if (recent_loads.size() != 0)
                    a = recent_loads[$urandom_range(0, recent_loads.size() - 1)];
            end
            8: a = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: ;
        endcase
        recent_loads.insert(recent_loads.size(), a);
        if (recent_loads.size() > 16)
            void'(recent_loads.pop_front());
        return a;
    endfunction

    function automatic req_item_t rand_item(input int load_pct, input int clear_pct);
        req_item_t it;
        int        r;
        it.addr    = $urandom;
        it.sel     = pass_t'($urandom_range(0, 3));
        it.restart = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < load_pct)
        begin
            it.kind = REQ_LOAD;
            it.addr = pick_address();
        end
        else if (r < load_pct + clear_pct)
            it.kind = REQ_CLEAR;
        else if (r < load_pct + clear_pct + 2)
            it.kind = REQ_NONE;
        else
            it.kind = REQ_NEXT;
        return it;
    endfunction

    task automatic queue_item(input req_item_t it);
        pending_reqs.insert(pending_reqs.size(), it);
    endtask

    task automatic push_req(input req_t kind, input logic [31:0] addr,
                            input pass_t sel, input logic rs);
        req_item_t it;
        it.kind    = kind;
        it.addr    = addr;
        it.sel     = sel;
        it.restart = rs;
        queue_item(it);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(int'(idx) * 4);
        pwdata  <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SINGLE_FIRST: shadow_cfg.single_first_octet = value;
            REG_PAIR_FIRST:   shadow_cfg.pair_first_octet   = value;
            REG_PAIR_SECOND:  shadow_cfg.pair_second_octet  = value;
            default:          shadow_cfg.any_octet_value    = value;
        endcase
    endtask

    task automatic write_filters(input logic [7:0] single, input logic [7:0] pf,
                                 input logic [7:0] ps, input logic [7:0] any);
        write_reg(REG_SINGLE_FIRST, single);
        write_reg(REG_PAIR_FIRST, pf);
        write_reg(REG_PAIR_SECOND, ps);
        write_reg(REG_ANY_OCTET, any);
    endtask

    // sample at the falling edge so all driver updates have settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_gap > 0)
            begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                drive_item   = pending_reqs.pop_front();
                req_type    <= drive_item.kind;
                address_in  <= drive_item.addr;
                pass_select <= drive_item.sel;
                restart     <= drive_item.restart;
                in_valid    <= 1'b1;
                in_gap      <= gap_len(in_steady);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // long hold-off on the result side so the block backs up its input
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            squeeze_left <= 0;
            hs_count     <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                hs_count <= hs_count + 1;
            if (in_valid && in_ready && (hs_count == 60 || hs_count == 330))
                squeeze_left <= SQUEEZE_LEN;
            else if (squeeze_left > 0)
                squeeze_left <= squeeze_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else if (squeeze_left > 0)
        begin
            out_ready <= 1'b0;
        end
        else if (out_stall > 0)
        begin
            out_stall <= out_stall - 1;
            out_ready <= 1'b0;
        end
        else if (!out_steady && $urandom_range(0, 5) == 0)
        begin
            out_stall <= gap_len(1'b0);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no item outstanding: status %0d address %h",
                           status, address_out);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatches++;
                    end
                    if (address_out !== want.addr)
                    begin
                        $error("address_out: expected %h, actual %h", want.addr, address_out);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                seen_item.kind    = req_t'(req_type);
                seen_item.addr    = address_in;
                seen_item.sel     = pass_t'(pass_select);
                seen_item.restart = restart;
                predicted         = apply_request(seen_item);
                expected_results.insert(expected_results.size(), predicted);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed items under the reset filter settings
        push_req(REQ_NEXT,  $urandom,      PASS_ALL,   1'b1); // empty store
        push_req(REQ_LOAD,  32'h0000_0000, PASS_ALL,   1'b0);
        push_req(REQ_LOAD,  32'hFFFF_FFFF, PASS_ANY,   1'b1);
        push_req(REQ_LOAD,  32'h2E46_0102, PASS_PAIR,  1'b0);
        push_req(REQ_LOAD,  32'h2E46_0102, PASS_ALL,   1'b0); // duplicate
        push_req(REQ_LOAD,  32'h0101_0101, PASS_FIRST, 1'b0);
        push_req(REQ_LOAD,  32'h0A00_2E05, PASS_ALL,   1'b1);
        push_req(REQ_LOAD,  32'h8000_0000, PASS_ALL,   1'b0);
        push_req(REQ_NEXT,  $urandom,      PASS_ALL,   1'b1);
        push_req(REQ_NEXT,  $urandom,      PASS_ALL,   1'b0);
        push_req(REQ_NEXT,  $urandom,      PASS_FIRST, 1'b1);
        push_req(REQ_NEXT,  $urandom,      PASS_FIRST, 1'b0); // runs out
        push_req(REQ_NEXT,  $urandom,      PASS_PAIR,  1'b1);
        push_req(REQ_NEXT,  $urandom,      PASS_PAIR,  1'b0);
        push_req(REQ_LOAD,  32'h2E46_FFFF, PASS_ALL,   1'b0); // load mid-pass
        push_req(REQ_NEXT,  $urandom,      PASS_PAIR,  1'b0);
        push_req(REQ_NEXT,  $urandom,      PASS_ANY,   1'b1);
        push_req(REQ_NEXT,  $urandom,      PASS_ANY,   1'b0);
        push_req(REQ_NONE,  $urandom,      PASS_ANY,   1'b1); // unused code
        push_req(REQ_NEXT,  $urandom,      PASS_ANY,   1'b0);
        push_req(REQ_CLEAR, $urandom,      PASS_ALL,   1'b0);
        push_req(REQ_NEXT,  $urandom,      PASS_ALL,   1'b0);
        push_req(REQ_LOAD,  32'h7FFF_FFFF, PASS_ALL,   1'b0);
        push_req(REQ_NEXT,  $urandom,      PASS_ALL,   1'b1);
        wait_drained();

        // low extreme of every filter, mixed traffic
        write_filters(8'd0, 8'd0, 8'd0, 8'd0);
        for (n = 0; n < 120; n++)
            queue_item(rand_item(50, 2));
        wait_drained();

        // high extreme, fill the store past full without idling
        in_steady  = 1'b1;
        out_steady = 1'b1;
        write_filters(8'd255, 8'd255, 8'd255, 8'd255);
        push_req(REQ_CLEAR, $urandom, PASS_ALL, 1'b0);
        for (n = 0; n < DEPTH + 6; n++)
            queue_item(rand_item(100, 0));
        for (n = 0; n < 40; n++)
            queue_item(rand_item(10, 0));
        wait_drained();

        // random settings, idle only on the input side
        in_steady  = 1'b0;
        write_filters(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        for (n = 0; n < 110; n++)
            queue_item(rand_item(45, 3));
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/isf_pkg.sv
rtl/isf_cfg.sv
rtl/isf_match.sv
rtl/isf_engine.sv
rtl/ipv4_sort_filter.sv
rtl/isf_chk.sv
sim/tb_ipv4_sort_filter.sv
